// ===== hw/rtl/cti_pkg.sv =====
// ----------------------------------------------------------------------------
// cti_pkg
// Shared constants and types for the cosine table interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

    localparam int ANGLE_W = 18;
    localparam int VALUE_W = 16;
    localparam int FOLD_W  = 15;
    localparam int SAMP_W  = 15;

    // Quadrant boundaries in Q3.14.
    localparam logic [ANGLE_W-1:0] HALF_PI_Q14       = 18'd25736;
    localparam logic [ANGLE_W-1:0] PI_Q14            = 18'd51472;
    localparam logic [ANGLE_W-1:0] THREE_HALF_PI_Q14 = 18'd77208;
    localparam logic [ANGLE_W-1:0] TWO_PI_Q14        = 18'd102944;

    // Position = folded * steps * 2^16 / 25736 = folded * steps * 2^13 / 3217.
    localparam int POS_FRAC_BITS = 16;
    localparam int DIV_SHIFT     = 13;
    localparam int DIV_ODD       = 3217;
    localparam int DIV_ODD_W     = 12;
    localparam int RECIP_SHIFT   = 40;
    localparam int RECIP_W       = 29;
    localparam longint unsigned RECIP_Q40 = (64'd1 << RECIP_SHIFT) / 64'd3217;

    // Sample generation, evaluated at elaboration only.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam int SERIES_TERMS = 9;
    localparam longint unsigned SERIES_DIV [1:SERIES_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306};

    typedef struct packed {
        logic oor;
        logic neg;
    } t_meta_s;

    typedef struct packed {
        t_meta_s            meta;
        logic [FOLD_W-1:0]  folded;
    } t_fold_s;

endpackage

// ===== hw/rtl/cti_fold.sv =====
// ----------------------------------------------------------------------------
// cti_fold
// Input register, magnitude and first-quadrant folding of the angle.
// ----------------------------------------------------------------------------
module cti_fold (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [17:0]            i_angle,
    output logic                          o_valid,
    output cti_pkg::t_fold_s              o_fold
);
    import cti_pkg::*;

    logic                     r_in_valid;
    logic [ANGLE_W-1:0]       r_angle;
    logic                     r_valid;
    t_fold_s                  r_fold;

    logic [ANGLE_W-1:0]       n_mag;
    logic [ANGLE_W-1:0]       n_rem;
    logic [1:0]               n_quad;
    t_fold_s                  n_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
            r_valid    <= r_in_valid;
        end
        r_angle <= i_angle;
        r_fold  <= n_fold;
    end

    always_comb begin
        // The most negative input maps to 2^17, which lands out of range.
        n_mag = r_angle[ANGLE_W-1] ? (~r_angle + 1'b1) : r_angle;
        if (n_mag >= THREE_HALF_PI_Q14) begin
            n_quad = 2'd3;
            n_rem  = n_mag - THREE_HALF_PI_Q14;
        end else if (n_mag >= PI_Q14) begin
            n_quad = 2'd2;
            n_rem  = n_mag - PI_Q14;
        end else if (n_mag >= HALF_PI_Q14) begin
            n_quad = 2'd1;
            n_rem  = n_mag - HALF_PI_Q14;
        end else begin
            n_quad = 2'd0;
            n_rem  = n_mag;
        end
        n_fold.meta.oor = (n_mag >= TWO_PI_Q14);
        n_fold.meta.neg = (n_quad == 2'd1) || (n_quad == 2'd2);
        // An out-of-range angle carries a zero folded angle so that the
        // later stages stay inside the table.
        if (n_fold.meta.oor) begin
            n_fold.folded = '0;
        end else begin
            n_fold.folded = n_quad[0] ? FOLD_W'(HALF_PI_Q14 - n_rem) : FOLD_W'(n_rem);
        end
    end

    assign o_valid = r_valid;
    assign o_fold  = r_fold;

    a_fold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_fold.folded <= FOLD_W'(HALF_PI_Q14)))
        else $error("folded angle beyond a quarter turn");
    a_fold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> ##1 r_valid)
        else $error("fold stage dropped a transfer");
    a_fold_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_angle == 18'h20000) |=> r_fold.meta.oor)
        else $error("most negative angle not flagged");

endmodule

// ===== hw/rtl/cti_scale.sv =====
// ----------------------------------------------------------------------------
// cti_scale
// Scales the folded angle to a table position with 16 fraction bits,
// dividing by a constant through a reciprocal product and one correction.
// ----------------------------------------------------------------------------
module cti_scale #(
    parameter int QUARTER_STEPS = 90
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  cti_pkg::t_fold_s                            i_fold,
    output logic                                        o_valid,
    output cti_pkg::t_meta_s                            o_meta,
    output logic [cti_pkg::POS_FRAC_BITS+$clog2(QUARTER_STEPS+1)-1:0] o_pos
);
    import cti_pkg::*;

    localparam int STEP_W = $clog2(QUARTER_STEPS + 1);
    localparam int P_W    = $clog2(25736 * QUARTER_STEPS + 1);
    localparam int N_W    = P_W + DIV_SHIFT;
    localparam int POS_W  = POS_FRAC_BITS + STEP_W;
    localparam int PROD_W = P_W + RECIP_W;
    localparam int QP_W   = POS_W + DIV_ODD_W;

    logic [2:0]         r_valid;
    t_meta_s            r_meta [0:2];
    logic [P_W-1:0]     r_p;
    logic [P_W-1:0]     r_p2;
    logic [POS_W-1:0]   r_q0;
    logic [POS_W-1:0]   r_pos;

    logic [P_W-1:0]     n_p;
    logic [PROD_W-1:0]  n_prod;
    logic [QP_W-1:0]    n_qd;
    logic [N_W-1:0]     n_num;
    logic [N_W-1:0]     n_rem;
    logic [POS_W-1:0]   n_pos;

    always_comb begin
        n_p    = P_W'(i_fold.folded) * P_W'(QUARTER_STEPS);
        n_prod = PROD_W'(r_p) * PROD_W'(RECIP_Q40);
        // The estimate is low by at most one; the remainder tells.
        n_qd   = QP_W'(r_q0) * QP_W'(DIV_ODD);
        n_num  = {r_p2, {DIV_SHIFT{1'b0}}};
        n_rem  = n_num - N_W'(n_qd);
        n_pos  = (n_rem >= N_W'(DIV_ODD)) ? (r_q0 + 1'b1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        r_meta[0] <= i_fold.meta;
        r_meta[1] <= r_meta[0];
        r_meta[2] <= r_meta[1];
        r_p       <= n_p;
        r_p2      <= r_p;
        r_q0      <= n_prod[RECIP_SHIFT-DIV_SHIFT +: POS_W];
        r_pos     <= n_pos;
    end

    assign o_valid = r_valid[2];
    assign o_meta  = r_meta[2];
    assign o_pos   = r_pos;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[2] |-> (r_pos <= (POS_W'(QUARTER_STEPS) << POS_FRAC_BITS)))
        else $error("table position beyond the last sample");
    a_rem_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] |-> (n_rem < N_W'(2 * DIV_ODD)))
        else $error("reciprocal estimate off by more than one");

endmodule

// ===== hw/rtl/cti_interp.sv =====
// ----------------------------------------------------------------------------
// cti_interp
// Sample lookup, linear interpolation between neighbors, sign and result
// register.
// ----------------------------------------------------------------------------
module cti_interp #(
    parameter int QUARTER_STEPS = 90
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  cti_pkg::t_meta_s                            i_meta,
    input  logic [cti_pkg::POS_FRAC_BITS+$clog2(QUARTER_STEPS+1)-1:0] i_pos,
    output logic                                        o_valid,
    output logic signed [15:0]                          o_value,
    output logic                                        o_out_of_range
);
    import cti_pkg::*;

    localparam int STEP_W = $clog2(QUARTER_STEPS + 1);
    localparam int ACC_W  = 2 * VALUE_W + 2;

    // Cosine of sample k, rounded to Q1.15 and clamped to 0..32767.
    function automatic logic [SAMP_W-1:0] cos_entry(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          rnd;
        x    = (longint'(k) * HALF_PI_Q30) / QUARTER_STEPS;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n];
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum <= 0) begin
            rnd = 0;
        end else begin
            rnd = (sum + 16384) >>> 15;
        end
        if (rnd > 32767) begin
            rnd = 32767;
        end
        return SAMP_W'(rnd);
    endfunction

    logic [SAMP_W-1:0] samp [0:QUARTER_STEPS];

    for (genvar g = 0; g <= QUARTER_STEPS; g++) begin : g_samp
        assign samp[g] = cos_entry(g);
    end

    logic [2:0]                 r_valid;
    t_meta_s                    r_meta [0:1];
    logic [SAMP_W-1:0]          r_left;
    logic [SAMP_W-1:0]          r_right;
    logic [POS_FRAC_BITS-1:0]   r_frac;
    logic [SAMP_W-1:0]          r_left2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [VALUE_W-1:0]  r_value;
    logic                       r_oor;

    logic [STEP_W-1:0]          n_idx;
    logic [STEP_W-1:0]          n_idx_r;
    logic signed [VALUE_W-1:0]  n_delta;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    n_sum;
    logic [SAMP_W-1:0]          n_res;
    logic signed [VALUE_W-1:0]  n_value;

    always_comb begin
        n_idx   = i_pos[POS_FRAC_BITS +: STEP_W];
        // At the quarter-turn point the fraction is zero and the last sample
        // stands alone.
        n_idx_r = (n_idx >= STEP_W'(QUARTER_STEPS)) ? STEP_W'(QUARTER_STEPS)
                                                     : n_idx + 1'b1;
        n_delta = signed'(VALUE_W'(r_right)) - signed'(VALUE_W'(r_left));
        n_acc   = ACC_W'(n_delta) * signed'(ACC_W'(r_frac))
                + signed'(ACC_W'(1 << (POS_FRAC_BITS - 1)));
        n_sum   = signed'(ACC_W'(r_left2)) + (r_acc >>> POS_FRAC_BITS);
        if (n_sum > signed'(ACC_W'(32767))) begin
            n_res = SAMP_W'(32767);
        end else if (n_sum < 0) begin
            n_res = '0;
        end else begin
            n_res = n_sum[SAMP_W-1:0];
        end
        if (r_meta[1].oor) begin
            n_value = '0;
        end else if (r_meta[1].neg) begin
            n_value = -signed'(VALUE_W'(n_res));
        end else begin
            n_value = signed'(VALUE_W'(n_res));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        r_meta[0] <= i_meta;
        r_meta[1] <= r_meta[0];
        r_left    <= samp[n_idx];
        r_right   <= samp[n_idx_r];
        r_frac    <= i_pos[POS_FRAC_BITS-1:0];
        r_left2   <= r_left;
        r_acc     <= n_acc;
        r_value   <= n_value;
        r_oor     <= r_meta[1].oor;
    end

    assign o_valid        = r_valid[2];
    assign o_value        = r_value;
    assign o_out_of_range = r_oor;

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] && r_meta[1].oor |=> (r_value == '0))
        else $error("out-of-range result not zero");
    a_pos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] && !r_meta[1].oor && !r_meta[1].neg |=> !r_value[VALUE_W-1])
        else $error("first or fourth quadrant result negative");
    a_interp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] |-> (n_sum >= 0) && (n_sum <= signed'(ACC_W'(32767))))
        else $error("interpolation left the sample range");

endmodule

// ===== hw/rtl/cosine_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// cosine_table_interpolator
// Cosine of a Q3.14 angle in Q1.15 by quarter-wave table and linear
// interpolation.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   command | i_start, o_busy, i_angle           | in
//   result  | o_valid, o_value, o_out_of_range   | out
//
// One angle is taken in every cycle; o_busy is always low.
// Each result appears in order, for one cycle, after passing the pipeline below.
// The pipeline holds the input register, fold, three scaling
// stages (multiply, reciprocal product, correction), lookup, interpolation
// multiply and the result register.
// Synchronous reset clears the valid chain; no clearing pass is needed.
// The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module cosine_table_interpolator #(
    parameter int QUARTER_STEPS = 90
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [17:0]  i_angle,
    output logic                o_valid,
    output logic signed [15:0]  o_value,
    output logic                o_out_of_range
);
    import cti_pkg::*;

    localparam int POS_W = POS_FRAC_BITS + $clog2(QUARTER_STEPS + 1);

    logic               fold_valid;
    t_fold_s            fold;
    logic               scale_valid;
    t_meta_s            scale_meta;
    logic [POS_W-1:0]   scale_pos;

    assign o_busy = 1'b0;

    cti_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_angle (i_angle),
        .o_valid (fold_valid),
        .o_fold  (fold)
    );

    cti_scale #(
        .QUARTER_STEPS (QUARTER_STEPS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fold_valid),
        .i_fold  (fold),
        .o_valid (scale_valid),
        .o_meta  (scale_meta),
        .o_pos   (scale_pos)
    );

    cti_interp #(
        .QUARTER_STEPS (QUARTER_STEPS)
    ) u_interp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (scale_valid),
        .i_meta         (scale_meta),
        .i_pos          (scale_pos),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_out_of_range (o_out_of_range)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##8 o_valid)
        else $error("result missing eight cycles after transfer");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_rst_n, 8) |-> $past(i_start, 8))
        else $error("result without a matching transfer");
    a_oor_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_value == 16'sd0))
        else $error("flagged result carries a value");

endmodule
